@@ src/rprs_pkg.sv @@
`timescale 1ns / 1ps

package rprs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int IDX_BITS     = 6;
  localparam int ELEMENT_BITS = 16;
  localparam int PREFIX_BITS  = 22;
  localparam int SUM_BITS     = 28;
  localparam int REG_BITS     = 7;
  localparam int CFG_IDX_BITS = 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COLS = 1'b1;

  typedef logic [PREFIX_BITS-1:0] prefix_t;

  typedef struct packed {
    logic                           op;
    logic [IDX_BITS-1:0]            row_index;
    logic [IDX_BITS-1:0]            col_index;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic [IDX_BITS-1:0]            row_from;
    logic [IDX_BITS-1:0]            col_from;
    logic [IDX_BITS-1:0]            row_to;
    logic [IDX_BITS-1:0]            col_to;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] rect_sum;
    logic                       status;
  } out_item_t;

endpackage

@@ src/rprs_mem.sv @@
`timescale 1ns / 1ps

// Prefix store held as two identical copies so that a row can be read at two
// columns in the same cycle. Both copies take every write.
module rprs_mem
  import rprs_pkg::*;
#(
  parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  prefix_t       wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output prefix_t       rdata_a,
  output prefix_t       rdata_b
);

  prefix_t mem_a [DEPTH];
  prefix_t mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
    end
    rdata_a <= mem_a[raddr_a];
    rdata_b <= mem_b[raddr_b];
  end

endmodule

@@ src/row_prefix_rectangle_sum.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Transfer when
// -------   ---------  -------------------------------  ----------------------
// input     in         in_valid, in_ready, in_data      in_valid && in_ready
// result    out        out_valid, out_ready, out_data   out_valid && out_ready
// config    in         cfg_wr_en, cfg_index, cfg_wdata  cfg_wr_en
//
// A load produces no result; a new item may follow at once.
// A good query walks one row per cycle over both copies of the prefix store; its result
// then passes the drain and done states before it is registered for output.
// A bad query goes straight to the done state, from which its result is registered.
// Reset is synchronous and active low; the prefix store itself is not cleared.
// While a result waits, loads and one further query are still taken; that query holds
// at its end until the result register frees, and the input stalls meanwhile.
module row_prefix_rectangle_sum
  import rprs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [REG_BITS-1:0]        num_rows_r, num_rows_nxt;
  logic [REG_BITS-1:0]        num_cols_r, num_cols_nxt;
  prefix_t                    run_sum_r, run_sum_nxt;
  logic [IDX_BITS-1:0]        row_r, row_nxt;
  logic [IDX_BITS-1:0]        row_to_r, row_to_nxt;
  logic [IDX_BITS-1:0]        c2_r, c2_nxt;
  logic [IDX_BITS-1:0]        c1m_r, c1m_nxt;
  logic                       has_lo_r, has_lo_nxt;
  logic                       rd_valid_r, rd_valid_nxt;
  logic signed [SUM_BITS-1:0] acc_r, acc_nxt;
  logic                       stat_r, stat_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;

  logic                       in_fire;
  logic                       load_ok;
  logic                       query_bad;
  logic                       mem_we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr_a;
  logic [AW-1:0]              raddr_b;
  prefix_t                    rdata_a;
  prefix_t                    rdata_b;
  logic signed [SUM_BITS-1:0] term_hi;
  logic signed [SUM_BITS-1:0] term_lo;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A register above the parameter acts as the parameter, so both limits apply.
  assign load_ok = ({1'b0, in_data.row_index} < num_rows_r)
                && (32'(in_data.row_index) < MAX_ROWS)
                && ({1'b0, in_data.col_index} < num_cols_r)
                && (32'(in_data.col_index) < MAX_COLS);

  assign query_bad = (in_data.row_from > in_data.row_to)
                  || (in_data.col_from > in_data.col_to)
                  || ({1'b0, in_data.row_to} >= num_rows_r)
                  || (32'(in_data.row_to) >= MAX_ROWS)
                  || ({1'b0, in_data.col_to} >= num_cols_r)
                  || (32'(in_data.col_to) >= MAX_COLS);

  assign mem_we  = in_fire && (in_data.op == OP_LOAD) && load_ok;

  // Row-major addressing; multiplication by a constant column count.
  assign waddr   = AW'(32'(in_data.row_index) * MAX_COLS + 32'(in_data.col_index));
  assign raddr_a = AW'(32'(row_r) * MAX_COLS + 32'(c2_r));
  assign raddr_b = AW'(32'(row_r) * MAX_COLS + 32'(c1m_r));

  // Stored prefixes are signed; widen to the width of the total.
  assign term_hi = SUM_BITS'(signed'(rdata_a));
  assign term_lo = has_lo_r ? SUM_BITS'(signed'(rdata_b)) : '0;

  rprs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (run_sum_nxt),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    state_nxt     = state_r;
    num_rows_nxt  = num_rows_r;
    num_cols_nxt  = num_cols_r;
    run_sum_nxt   = run_sum_r;
    row_nxt       = row_r;
    row_to_nxt    = row_to_r;
    c2_nxt        = c2_r;
    c1m_nxt       = c1m_r;
    has_lo_nxt    = has_lo_r;
    rd_valid_nxt  = 1'b0;
    acc_nxt       = acc_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows_nxt = cfg_wdata;
        CFG_NUM_COLS: num_cols_nxt = cfg_wdata;
        default:      ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Each read pair arrives in the cycle after its address was issued.
    if (rd_valid_r) begin
      acc_nxt = acc_r + term_hi - term_lo;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_LOAD) begin
            if (load_ok) begin
              // The running sum restarts at column 0 and wraps in its width.
              run_sum_nxt = ((in_data.col_index == '0) ? '0 : run_sum_r)
                          + PREFIX_BITS'(in_data.element_value);
            end
          end else begin
            acc_nxt    = '0;
            row_nxt    = in_data.row_from;
            row_to_nxt = in_data.row_to;
            c2_nxt     = in_data.col_to;
            c1m_nxt    = in_data.col_from - IDX_BITS'(1);
            has_lo_nxt = (in_data.col_from != '0);
            if (query_bad) begin
              stat_nxt  = STATUS_BAD;
              state_nxt = S_DONE;
            end else begin
              stat_nxt  = STATUS_OK;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        rd_valid_nxt = 1'b1;
        if (row_r == row_to_r) begin
          state_nxt = S_DRAIN;
        end else begin
          row_nxt = row_r + IDX_BITS'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.rect_sum = acc_r;
          out_data_nxt.status   = stat_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_rows_r  <= REG_BITS'(64);
      num_cols_r  <= REG_BITS'(64);
      run_sum_r   <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_rows_r  <= num_rows_nxt;
      num_cols_r  <= num_cols_nxt;
      run_sum_r   <= run_sum_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r      <= row_nxt;
    row_to_r   <= row_to_nxt;
    c2_r       <= c2_nxt;
    c1m_r      <= c1m_nxt;
    has_lo_r   <= has_lo_nxt;
    acc_r      <= acc_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // The store is only written while no query walk is in progress.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE))
    else $error("prefix store written during a query walk");

  // Read data is only consumed in the cycle after a walk step.
  a_rd_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> ((state_r == S_WALK) || (state_r == S_DRAIN)))
    else $error("read data taken outside a walk");

  // The walk never runs past its last row.
  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (row_r <= row_to_r))
    else $error("walk row beyond the last row of the rectangle");

  // A rejected rectangle always reports a zero sum.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == STATUS_BAD)) |-> (out_data_r.rect_sum == '0))
    else $error("bad query returned a non-zero sum");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the row prefix rectangle-sum block.
//
// Loads store running row prefix sums in the block. Queries return the sum over a
// rectangle, or status bad with a zero sum. A shadow copy of the prefix store, the
// running sum and both size registers is kept in this module. It is updated at every
// accepted input transfer. Each query pushes its expected result onto a queue. The
// result monitor pops that queue on every output transfer and compares field by field.
//
// The prefix store is not cleared by reset. A bitmap therefore records which entries
// have been written, and no good query is sent that would read an entry that was
// never loaded.
module testbench;
  import rprs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0]     cfg_wdata;

  // Shadow state of the block.
  logic signed [PREFIX_BITS-1:0] prefix_mem [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
  bit                            loaded     [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
  logic signed [PREFIX_BITS-1:0] running_sum;
  logic [REG_BITS-1:0]           rows_reg;
  logic [REG_BITS-1:0]           cols_reg;

  // Results still owed by the block, oldest first.
  out_item_t sums_due[$];

  int unsigned err_count;
  // Accepted items that did something: queries, and loads that landed in range.
  int unsigned items_applied;
  // The row most recently loaded in order, so that queries can aim at known data.
  int recent_row;
  int recent_last_col;
  // Burst modes switch off the random idle cycles on either side.
  bit tx_burst;
  bit rx_burst;
  // Set by a test to make the result side hold off for a long stretch.
  bit hold_req;

  row_prefix_rectangle_sum DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A size register above the array maximum behaves as the maximum.
  function automatic int rows_in_use();
    return (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
  endfunction

  function automatic int cols_in_use();
    return (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
  endfunction

  // The store is laid out by the array maximum, whatever the sizes in use.
  function automatic int store_addr(input int row, input int col);
    return row * MAX_COLS_DEF + col;
  endfunction

  function automatic bit rect_out_of_range(input in_item_t q);
    return (q.row_from > q.row_to) || (q.col_from > q.col_to) ||
           (q.row_to >= rows_in_use()) || (q.col_to >= cols_in_use());
  endfunction

  // A bad query reads nothing. A good one reads column col_to and, where col_from is
  // not zero, column col_from-1 of every row it covers.
  function automatic bit reads_only_loaded(input in_item_t q);
    int r;
    if (rect_out_of_range(q)) return 1'b1;
    for (r = q.row_from; r <= q.row_to; r++) begin
      if (!loaded[store_addr(r, q.col_to)]) return 1'b0;
      if (q.col_from != '0 && !loaded[store_addr(r, q.col_from - 1)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one accepted transfer to the shadow state. It returns 1 when the item
  // produces a result, and that result is placed in sum_out.
  function automatic bit prefix_sum_step(input in_item_t it, output out_item_t sum_out);
    logic signed [ELEMENT_BITS-1:0] elem;
    logic signed [SUM_BITS-1:0]     total;
    int                             r;
    sum_out = '0;
    if (it.op == OP_LOAD) begin
      if (it.row_index >= rows_in_use() || it.col_index >= cols_in_use()) return 1'b0;
      elem = it.element_value;
      // Column zero restarts the running sum. Any other column carries on from the
      // current running sum, even one left over from a different row. The sum wraps
      // in the prefix width.
      if (it.col_index == '0) running_sum = elem;
      else running_sum = running_sum + elem;
      prefix_mem[store_addr(it.row_index, it.col_index)] = running_sum;
      loaded[store_addr(it.row_index, it.col_index)] = 1'b1;
      items_applied++;
      return 1'b0;
    end
    items_applied++;
    if (rect_out_of_range(it)) begin
      sum_out.rect_sum = '0;
      sum_out.status   = STATUS_BAD;
      return 1'b1;
    end
    total = '0;
    for (r = it.row_from; r <= it.row_to; r++) begin
      total = total + prefix_mem[store_addr(r, it.col_to)];
      if (it.col_from != '0) total = total - prefix_mem[store_addr(r, it.col_from - 1)];
    end
    sum_out.rect_sum = total;
    sum_out.status   = STATUS_OK;
    return 1'b1;
  endfunction

  // Fields that the operation does not use are left random.
  function automatic in_item_t random_fields();
    logic [$bits(in_item_t)-1:0] raw;
    raw = $bits(in_item_t)'({$urandom, $urandom});
    return raw;
  endfunction

  function automatic in_item_t make_load(input int row, input int col, input int value);
    in_item_t it;
    it               = random_fields();
    it.op            = OP_LOAD;
    it.row_index     = row[IDX_BITS-1:0];
    it.col_index     = col[IDX_BITS-1:0];
    it.element_value = value[ELEMENT_BITS-1:0];
    return it;
  endfunction

  function automatic in_item_t make_query(input int r1, input int c1, input int r2,
                                          input int c2);
    in_item_t it;
    it          = random_fields();
    it.op       = OP_QUERY;
    it.row_from = r1[IDX_BITS-1:0];
    it.col_from = c1[IDX_BITS-1:0];
    it.row_to   = r2[IDX_BITS-1:0];
    it.col_to   = c2[IDX_BITS-1:0];
    return it;
  endfunction

  function automatic int pick_element();
    case ($urandom_range(0, 7))
      0:       return 32767;
      1:       return -32768;
      default: return int'($signed($urandom_range(0, 65535) - 32768));
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return 64;
      2:       return $urandom_range(1, 8);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // Looks for a good rectangle over loaded data. Half of the attempts aim at the row
  // loaded most recently. If no attempt fits, it falls back to an inverted rectangle.
  function automatic in_item_t pick_loaded_rect();
    in_item_t q;
    int       rmax, cmax, r1, r2, c1, c2;
    rmax = rows_in_use() - 1;
    cmax = cols_in_use() - 1;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0 && recent_row <= rmax && recent_last_col <= cmax) begin
        r1 = recent_row;
        c2 = $urandom_range(0, recent_last_col);
      end else begin
        r1 = $urandom_range(0, rmax);
        c2 = $urandom_range(0, cmax);
      end
      c1 = $urandom_range(0, c2);
      if ($urandom_range(0, 3) == 0) r2 = $urandom_range(r1, rmax);
      else r2 = r1 + $urandom_range(0, 2);
      if (r2 > rmax) r2 = rmax;
      q = make_query(r1, c1, r2, c2);
      if (reads_only_loaded(q)) return q;
    end
    return make_query(1, 0, 0, 0);
  endfunction

  // All fields are random. If the rectangle would touch unloaded entries, its rows
  // are inverted so that the query is rejected instead.
  function automatic in_item_t random_query();
    in_item_t q;
    q    = random_fields();
    q.op = OP_QUERY;
    if (!reads_only_loaded(q)) begin
      if (q.row_to == 6'd63) q.row_to = 6'd62;
      q.row_from = q.row_to + 6'd1;
    end
    return q;
  endfunction

  // Offers one item and returns at the clock edge where it transfers. Valid is only
  // lowered when a gap is drawn, so back-to-back items keep it high throughout.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    out_item_t   res;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (prefix_sum_step(it, res)) sums_due.push_back(res);
  endtask

  task automatic load_row(input int row, input int last_col);
    recent_row      = row;
    recent_last_col = last_col;
    for (int c = 0; c <= last_col; c++) send_item(make_load(row, c, pick_element()));
  endtask

  // Waits until every owed result has arrived. A trailing load produces no result,
  // so the task goes on waiting after that for it to land.
  task automatic drain();
    in_valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[REG_BITS-1:0];
    @(posedge clk);
    if (idx == CFG_NUM_ROWS) rows_reg = value[REG_BITS-1:0];
    else cols_reg = value[REG_BITS-1:0];
  endtask

  task automatic apply_sizes(input int rows, input int cols);
    drain();
    write_reg(CFG_NUM_ROWS, rows);
    write_reg(CFG_NUM_COLS, cols);
    cfg_wr_en <= 1'b0;
  endtask

  // Covers extreme element values, a row that skips columns after column zero,
  // queries starting at column zero and beyond it, and inverted rectangles.
  task automatic test_directed();
    send_item(make_load(0, 0, -32768));
    send_item(make_load(0, 1, 32767));
    send_item(make_load(0, 2, 0));
    send_item(make_load(63, 0, 1));
    send_item(make_load(63, 63, -1));
    send_item(make_query(0, 0, 0, 2));
    send_item(make_query(0, 1, 0, 2));
    send_item(make_query(0, 2, 0, 2));
    send_item(make_query(63, 0, 63, 63));
    send_item(make_query(1, 0, 0, 0));
    send_item(make_query(0, 2, 0, 1));
    send_item(make_query(63, 63, 0, 0));
  endtask

  // Tests the smallest sizes, a size of zero, where nothing is in range, and sizes
  // above the array maximum, which act as that maximum.
  task automatic test_size_extremes();
    apply_sizes(1, 1);
    send_item(make_load(0, 0, 7));
    send_item(make_load(1, 0, 9));
    send_item(make_load(0, 1, 9));
    send_item(make_load(63, 63, -5));
    send_item(make_query(0, 0, 0, 0));
    send_item(make_query(0, 0, 1, 0));
    send_item(make_query(0, 0, 0, 1));
    apply_sizes(0, 0);
    send_item(make_load(0, 0, 3));
    send_item(make_query(0, 0, 0, 0));
    apply_sizes(127, 127);
    send_item(make_query(0, 0, 0, 0));
    send_item(make_load(63, 63, 2));
    send_item(make_query(63, 0, 63, 63));
  endtask

  // Row 0 is filled with the largest element value. After that, each further row gets
  // loads in columns 62 and 63 only. The running sum carries on from row to row, so
  // it wraps through the prefix width twice per row. The difference between those two
  // columns is then close to the full prefix range. Summed over every row, that
  // overflows the result width as well.
  task automatic test_running_wrap();
    apply_sizes(64, 64);
    for (int c = 0; c < 64; c++) send_item(make_load(0, c, 32767));
    for (int r = 1; r < 64; r++) begin
      send_item(make_load(r, 62, 32767));
      send_item(make_load(r, 63, -32768));
    end
    send_item(make_query(0, 63, 63, 63));
    send_item(make_query(1, 63, 63, 63));
    send_item(make_query(0, 0, 63, 63));
  endtask

  // The result side holds off for a long stretch while items are offered back to
  // back. Loads should still be taken, but a second query fills the block and the
  // input stalls until results are taken again.
  task automatic test_backpressure();
    apply_sizes(64, 64);
    tx_burst = 1'b1;
    hold_req = 1'b1;
    load_row(5, 15);
    send_item(make_query(0, 0, 0, 63));
    send_item(make_query(5, 0, 5, 15));
    send_item(make_query(0, 3, 0, 40));
    send_item(make_query(5, 4, 5, 9));
    send_item(make_query(1, 0, 0, 0));
    send_item(make_query(1, 63, 4, 63));
    load_row(6, 63);
    send_item(make_query(6, 10, 6, 63));
    tx_burst = 1'b0;
  endtask

  // Random phases, each with its own sizes and idle modes. Most of the traffic is
  // in-order row loads and queries over loaded data. The rest is loads at arbitrary
  // positions and queries with random fields.
  task automatic test_random(input int unsigned amount);
    int unsigned stop_at, phase_end, sel;
    stop_at = items_applied + amount;
    while (items_applied < stop_at) begin
      apply_sizes(pick_size(), pick_size());
      tx_burst  = ($urandom_range(0, 3) == 0);
      rx_burst  = ($urandom_range(0, 3) == 0);
      phase_end = items_applied + 250;
      while (items_applied < phase_end && items_applied < stop_at) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          load_row($urandom_range(0, rows_in_use() - 1),
                   $urandom_range(0, cols_in_use() - 1));
        end else if (sel < 75) begin
          send_item(pick_loaded_rect());
        end else if (sel < 90) begin
          send_item(make_load($urandom_range(0, 63), $urandom_range(0, 63),
                              pick_element()));
        end else begin
          send_item(random_query());
        end
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Result side. After each transfer it draws a random stall, unless it is in burst
  // mode. It also honours a long hold when a test asks for one. Ready is assigned once
  // per clock.
  initial begin : result_monitor
    out_item_t   got;
    out_item_t   want;
    int unsigned stall;
    int unsigned hold_left;
    stall     = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = out_data;
        if (sums_due.size() == 0) begin
          $display("%0t: result with no query outstanding: rect_sum %0d status %0d",
                   $time, got.rect_sum, got.status);
          err_count++;
        end else begin
          want = sums_due.pop_front();
          if (got.rect_sum !== want.rect_sum) begin
            $display("%0t: rect_sum expected %0d, got %0d", $time, want.rect_sum,
                     got.rect_sum);
            err_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     got.status);
            err_count++;
          end
        end
        stall = rx_burst ? 0 : $urandom_range(0, 15);
      end else if (stall > 0) begin
        stall--;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready <= (stall == 0) && (hold_left == 0);
    end
  end

  // Ends a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL row_prefix_rectangle_sum");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_NUM_ROWS;
    cfg_wdata <= '0;
    rows_reg        = 7'd64;
    cols_reg        = 7'd64;
    running_sum     = '0;
    err_count       = 0;
    items_applied   = 0;
    recent_row      = 0;
    recent_last_col = 0;
    tx_burst        = 1'b0;
    rx_burst        = 1'b0;
    hold_req        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_size_extremes();
    test_running_wrap();
    test_backpressure();
    test_random(2000);

    // Allow for the longest query walk after the final result.
    drain();
    repeat (100) @(posedge clk);
    if (sums_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sums_due.size());
      err_count++;
    end
    if (err_count == 0) $display("PASS row_prefix_rectangle_sum");
    else $display("FAIL row_prefix_rectangle_sum");
    $finish;
  end

endmodule

@@ row_prefix_rectangle_sum.f @@
src/rprs_pkg.sv
src/rprs_mem.sv
src/row_prefix_rectangle_sum.sv
tb/testbench.sv
